FILE: rtl/hhls_pkg.sv
// Package for the hex hash loader and serializer.
// Holds sizes, item structs, state encodings and the hex digit decoder.
// No dependencies.
package hhls_pkg;

    localparam int HASH_CHARS = 32;
    localparam int CNT_W      = 6;
    localparam int IDX_W      = (HASH_CHARS > 1) ? $clog2(HASH_CHARS) : 1;

    typedef struct packed {
        logic [7:0] key_code;
        logic       reset_button;
        logic       ready_button;
    } t_in_item;

    typedef struct packed {
        logic             item_kind;
        logic [3:0]       nibble;
        logic             last_item;
        logic [CNT_W-1:0] chars_entered;
        logic             hash_complete;
        logic             transferring;
        logic             running;
        logic             engine_run;
        logic             engine_reset;
    } t_out_item;

    typedef enum logic [2:0] {
        KD_INIT = 3'b001,
        KD_WAIT = 3'b010,
        KD_HELD = 3'b100
    } t_kd_state;

    typedef enum logic [5:0] {
        CS_INIT  = 6'b000001,
        CS_ENTRY = 6'b000010,
        CS_READY = 6'b000100,
        CS_XFER  = 6'b001000,
        CS_RUN   = 6'b010000,
        CS_RESET = 6'b100000
    } t_cs_state;

    // Hex character to nibble, either case; anything else decodes to zero.
    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [3:0] v;
        v = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[3:0] + 4'h9;
        end
        return v;
    endfunction

endpackage

FILE: rtl/hhls_if.sv
// Valid/ready channel interfaces for the hex hash loader and serializer.
// Depends on hhls_pkg for the payload structs.
interface hhls_in_if;
    import hhls_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hhls_out_if;
    import hhls_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/hex_hash_loader_serializer.sv
// Hex hash loader and serializer top level.
// A tick's first result is valid in the cycle after acceptance. A transfer tick
// emits HASH_CHARS nibble transactions, one per cycle while o_out.ready holds,
// shifted out of the nibble shift register; ticks stall while results pend.
// Reset (i_rst_n, synchronous, active low) clears all control state; the
// buffer itself is not cleared, every entry is rewritten before a transfer.
module hex_hash_loader_serializer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hhls_in_if.sink    i_in,
    hhls_out_if.source o_out
);
    import hhls_pkg::*;

    t_kd_state        r_kd, n_kd;
    t_cs_state        r_cs, n_cs;
    logic [7:0]       r_cap, n_cap;
    logic             r_pend, n_pend;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ready, n_ready;
    logic             r_xfer, n_xfer;
    logic             r_running, n_running;
    logic             r_run, n_run;
    logic             r_pulse, n_pulse;
    logic             r_out_valid, n_out_valid;
    logic             r_emit, n_emit;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [3:0]       r_buf [HASH_CHARS];

    logic             w_acc;
    logic             w_store;
    logic             w_shift_out;
    logic             w_last;

    assign w_acc  = i_in.valid && i_in.ready;
    assign w_last = (r_idx == IDX_W'(HASH_CHARS - 1));
    assign i_in.ready = !r_out_valid;

    always_comb begin
        n_kd        = r_kd;
        n_cs        = r_cs;
        n_cap       = r_cap;
        n_pend      = r_pend;
        n_count     = r_count;
        n_ready     = r_ready;
        n_xfer      = r_xfer;
        n_running   = r_running;
        n_run       = r_run;
        n_pulse     = r_pulse;
        n_out_valid = r_out_valid;
        n_emit      = r_emit;
        n_idx       = r_idx;
        w_store     = 1'b0;
        w_shift_out = 1'b0;
        if (w_acc) begin
            n_pulse = 1'b0;
            n_emit  = 1'b0;
            unique case (r_kd)
                KD_INIT: n_kd = KD_WAIT;
                KD_WAIT: begin
                    if (i_in.data.key_code != 8'h00) begin
                        n_cap  = i_in.data.key_code;
                        n_pend = 1'b1;
                        n_kd   = KD_HELD;
                    end
                end
                KD_HELD: begin
                    if (i_in.data.key_code == 8'h00) n_kd = KD_WAIT;
                end
                default: n_kd = KD_INIT;
            endcase
            unique case (r_cs)
                CS_INIT: n_run = 1'b0;
                CS_ENTRY: begin
                    if (n_pend && r_count < CNT_W'(HASH_CHARS)) begin
                        w_store = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        n_pend  = 1'b0;
                    end
                    if (n_count >= CNT_W'(HASH_CHARS)) n_ready = 1'b1;
                end
                CS_XFER: begin
                    n_xfer  = 1'b1;
                    n_pulse = 1'b1;
                    n_emit  = 1'b1;
                end
                CS_RUN: begin
                    n_running = 1'b1;
                    n_run     = 1'b1;
                end
                CS_RESET: begin
                    n_run   = 1'b0;
                    n_pulse = 1'b1;
                    n_ready = 1'b0;
                    n_count = '0;
                    n_pend  = 1'b0;
                    n_xfer  = 1'b0;
                end
                default: ;
            endcase
            unique case (r_cs)
                CS_INIT: n_cs = CS_ENTRY;
                CS_ENTRY: begin
                    if (i_in.data.reset_button) n_cs = CS_RESET;
                    else if (n_ready) n_cs = CS_READY;
                end
                CS_READY: begin
                    if (i_in.data.reset_button) n_cs = CS_RESET;
                    else if (i_in.data.ready_button) n_cs = CS_XFER;
                end
                CS_XFER: n_cs = CS_RUN;
                CS_RUN: begin
                    if (i_in.data.reset_button) begin
                        n_cs      = CS_RESET;
                        n_running = 1'b0;
                    end
                end
                CS_RESET: n_cs = CS_INIT;
                default: n_cs = CS_INIT;
            endcase
            n_out_valid = 1'b1;
            n_idx       = '0;
        end else if (r_out_valid && o_out.ready) begin
            if (r_emit && !w_last) begin
                n_idx       = r_idx + IDX_W'(1);
                w_shift_out = 1'b1;
            end else begin
                n_out_valid = 1'b0;
                n_emit      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kd        <= KD_INIT;
            r_cs        <= CS_INIT;
            r_cap       <= '0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_ready     <= 1'b0;
            r_xfer      <= 1'b0;
            r_running   <= 1'b0;
            r_run       <= 1'b0;
            r_pulse     <= 1'b0;
            r_out_valid <= 1'b0;
            r_emit      <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_kd        <= n_kd;
            r_cs        <= n_cs;
            r_cap       <= n_cap;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_ready     <= n_ready;
            r_xfer      <= n_xfer;
            r_running   <= n_running;
            r_run       <= n_run;
            r_pulse     <= n_pulse;
            r_out_valid <= n_out_valid;
            r_emit      <= n_emit;
            r_idx       <= n_idx;
        end
    end

    // Newest character sits at the head; the transfer drains from the head.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_buf[0] <= hex_nib(n_cap);
            for (int i = 1; i < HASH_CHARS; i++) r_buf[i] <= r_buf[i-1];
        end else if (w_shift_out) begin
            for (int i = 0; i < HASH_CHARS - 1; i++) r_buf[i] <= r_buf[i+1];
            r_buf[HASH_CHARS-1] <= 4'h0;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.data.item_kind     = r_emit;
    assign o_out.data.nibble        = r_emit ? r_buf[0] : 4'h0;
    assign o_out.data.last_item     = !r_emit || w_last;
    assign o_out.data.chars_entered = r_count;
    assign o_out.data.hash_complete = r_ready;
    assign o_out.data.transferring  = r_xfer;
    assign o_out.data.running       = r_running;
    assign o_out.data.engine_run    = r_run;
    assign o_out.data.engine_reset  = r_pulse;

`ifndef NO_ASSERTIONS
    a_emit_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> (r_xfer && r_pulse && r_out_valid))
        else $error("nibble transaction without transfer");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HASH_CHARS))
        else $error("character count overflow");
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_count == CNT_W'(HASH_CHARS)))
        else $error("ready flag with partial buffer");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !i_in.ready)
        else $error("tick accepted while results pending");
`endif

endmodule

FILE: sim/hex_hash_loader_serializer_tb.sv
// Self-checking testbench for hex_hash_loader_serializer: keypad ticks in, status
// and nibble transactions out, each checked against an in-bench loader model.
// Depends on hhls_pkg, hhls_if and the RTL top level.
`timescale 1ns / 100ps

module hex_hash_loader_serializer_tb;
    import hhls_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 8;

    localparam logic [7:0] ASCII_0  = 8'h30;
    localparam logic [7:0] ASCII_9  = 8'h39;
    localparam logic [7:0] ASCII_UA = 8'h41;
    localparam logic [7:0] ASCII_UF = 8'h46;
    localparam logic [7:0] ASCII_LA = 8'h61;
    localparam logic [7:0] ASCII_LF = 8'h66;
    localparam logic [7:0] ASCII_SP = 8'h20;
    localparam logic [7:0] NO_KEY   = 8'h00;

    logic i_clk;
    logic i_rst_n;

    hhls_in_if  in_if ();
    hhls_out_if out_if ();

    hex_hash_loader_serializer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // loader model state
    t_kd_state  key_phase;
    t_cs_state  ctrl_phase;
    logic [7:0] latched_key;
    logic       key_pending;
    int         stored_count;
    logic [7:0] hash_buf [HASH_CHARS];
    logic       buf_full;
    logic       xfer_done;
    logic       engine_running;
    logic       run_level;

    t_out_item  loader_out_q [$];

    int error_count   = 0;
    int result_count  = 0;
    int ticks_sent    = 0;
    int cycle_count   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int stall_left    = 0;
    bit idle_enable   = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [3:0] hex_digit_value(input logic [7:0] c);
        if (c >= ASCII_0 && c <= ASCII_9) return 4'(c - ASCII_0);
        if (c >= ASCII_UA && c <= ASCII_UF) return 4'(c - ASCII_UA + 8'd10);
        if (c >= ASCII_LA && c <= ASCII_LF) return 4'(c - ASCII_LA + 8'd10);
        return 4'h0;
    endfunction

    function automatic t_out_item loader_status();
        t_out_item r;
        r = '0;
        r.chars_entered = 6'(stored_count);
        r.hash_complete = buf_full;
        r.transferring  = xfer_done;
        r.running       = engine_running;
        r.engine_run    = run_level;
        return r;
    endfunction

    task automatic predict_loader_tick(input t_in_item it);
        t_out_item r;
        logic      pulse;
        logic      xfer;
        pulse = 1'b0;
        xfer  = 1'b0;
        case (key_phase)
            KD_INIT: key_phase = KD_WAIT;
            KD_WAIT: begin
                if (it.key_code != NO_KEY) begin
                    latched_key = it.key_code;
                    key_pending = 1'b1;
                    key_phase   = KD_HELD;
                end
            end
            KD_HELD: begin
                if (it.key_code == NO_KEY) key_phase = KD_WAIT;
            end
            default: key_phase = KD_INIT;
        endcase

        case (ctrl_phase)
            CS_INIT: run_level = 1'b0;
            CS_ENTRY: begin
                if (key_pending && stored_count < HASH_CHARS) begin
                    hash_buf[stored_count] = latched_key;
                    stored_count++;
                    key_pending = 1'b0;
                end
                if (stored_count >= HASH_CHARS) buf_full = 1'b1;
            end
            CS_XFER: begin
                xfer_done = 1'b1;
                pulse     = 1'b1;
                xfer      = 1'b1;
            end
            CS_RUN: begin
                engine_running = 1'b1;
                run_level      = 1'b1;
            end
            CS_RESET: begin
                run_level    = 1'b0;
                pulse        = 1'b1;
                buf_full     = 1'b0;
                stored_count = 0;
                key_pending  = 1'b0;
                xfer_done    = 1'b0;
                foreach (hash_buf[i]) hash_buf[i] = ASCII_SP;
            end
            default: ;
        endcase

        case (ctrl_phase)
            CS_INIT: ctrl_phase = CS_ENTRY;
            CS_ENTRY: begin
                if (it.reset_button) ctrl_phase = CS_RESET;
                else if (buf_full) ctrl_phase = CS_READY;
            end
            CS_READY: begin
                if (it.reset_button) ctrl_phase = CS_RESET;
                else if (it.ready_button) ctrl_phase = CS_XFER;
            end
            CS_XFER: ctrl_phase = CS_RUN;
            CS_RUN: begin
                if (it.reset_button) begin
                    ctrl_phase     = CS_RESET;
                    engine_running = 1'b0;
                end
            end
            CS_RESET: ctrl_phase = CS_INIT;
            default: ctrl_phase = CS_INIT;
        endcase

        r = loader_status();
        if (xfer) begin
            r.item_kind    = 1'b1;
            r.engine_reset = 1'b1;
            for (int k = 0; k < HASH_CHARS; k++) begin
                r.nibble    = hex_digit_value(hash_buf[HASH_CHARS - 1 - k]);
                r.last_item = (k == HASH_CHARS - 1);
                loader_out_q.push_back(r);
            end
        end else begin
            r.last_item    = 1'b1;
            r.engine_reset = pulse;
            loader_out_q.push_back(r);
        end
    endtask

    function automatic t_in_item make_tick(input logic [7:0] code, input logic rst,
                                           input logic rdy);
        t_in_item it;
        it.key_code     = code;
        it.reset_button = rst;
        it.ready_button = rdy;
        return it;
    endfunction

    function automatic logic [7:0] pick_hash_char();
        logic [7:0] edges [6];
        int         sel;
        edges = '{8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67};
        sel   = $urandom_range(0, 9);
        if (sel <= 3) return ASCII_0 + 8'($urandom_range(0, 9));
        if (sel <= 5) return ASCII_UA + 8'($urandom_range(0, 5));
        if (sel <= 7) return ASCII_LA + 8'($urandom_range(0, 5));
        if (sel == 8) return 8'($urandom_range(1, 255));
        return edges[$urandom_range(0, 5)];
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_error($sformatf("result %0d field %s got %0d want %0d",
                                 result_count, name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (loader_out_q.size() == 0) begin
                flag_error($sformatf("unexpected transaction %0d", result_count));
            end else begin
                want = loader_out_q.pop_front();
                check_field("item_kind", got.item_kind, want.item_kind);
                check_field("nibble", got.nibble, want.nibble);
                check_field("last_item", got.last_item, want.last_item);
                check_field("chars_entered", got.chars_entered, want.chars_entered);
                check_field("hash_complete", got.hash_complete, want.hash_complete);
                check_field("transferring", got.transferring, want.transferring);
                check_field("running", got.running, want.running);
                check_field("engine_run", got.engine_run, want.engine_run);
                check_field("engine_reset", got.engine_reset, want.engine_reset);
            end
            result_count++;
        end
    end

    // output side: random stall bursts, plus long holds on request
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && idle_enable && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input t_in_item it);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        predict_loader_tick(it);
        ticks_sent++;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (loader_out_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // one load / transfer / run / reset pass; noisy passes add stray keys and
    // aborts by the reset button, and any pass may add held keys
    task automatic run_hash_cycle(input bit noisy);
        int         abort_at;
        bit         abort_ready;
        logic [7:0] ch;
        abort_at    = (noisy && $urandom_range(0, 1)) ? $urandom_range(1, HASH_CHARS - 1) : -1;
        abort_ready = noisy && ($urandom_range(0, 5) == 0);
        while (ctrl_phase != CS_READY) begin
            if (stored_count == abort_at) begin
                abort_at = -1;
                send_tick(make_tick(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1))));
            end else if (noisy && $urandom_range(0, 7) == 0) begin
                send_tick(make_tick(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1))));
            end else begin
                ch = pick_hash_char();
                send_tick(make_tick(ch, 1'b0, $urandom_range(0, 7) == 0));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_tick(make_tick(8'($urandom_range(1, 255)), 1'b0, 1'b0));
                send_tick(make_tick(NO_KEY, 1'b0, 1'b0));
            end
        end
        while (ctrl_phase == CS_READY) begin
            if (abort_ready)
                send_tick(make_tick(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1))));
            else
                send_tick(make_tick(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 2) == 0));
        end
        if (ctrl_phase != CS_XFER) return;
        // buttons have no effect on the transfer tick
        send_tick(make_tick(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1))));
        repeat ($urandom_range(1, 4))
            send_tick(make_tick(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1))));
        send_tick(make_tick(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1))));
    endtask

    task automatic test_key_edges();
        send_tick(make_tick(NO_KEY, 1'b0, 1'b0));
        send_tick(make_tick(8'hff, 1'b0, 1'b0));
        send_tick(make_tick(8'hff, 1'b0, 1'b1));
        send_tick(make_tick(NO_KEY, 1'b0, 1'b0));
        send_tick(make_tick(8'h01, 1'b0, 1'b0));
        send_tick(make_tick(NO_KEY, 1'b0, 1'b0));
        send_tick(make_tick(8'h80, 1'b0, 1'b1));
        send_tick(make_tick(8'h7f, 1'b0, 1'b0));
        send_tick(make_tick(NO_KEY, 1'b0, 1'b0));
        send_tick(make_tick(ASCII_LA, 1'b0, 1'b0));
        // reset during entry, then a press caught during the reset tick is dropped
        send_tick(make_tick(NO_KEY, 1'b1, 1'b0));
        send_tick(make_tick(ASCII_UF, 1'b0, 1'b0));
        send_tick(make_tick(NO_KEY, 1'b0, 1'b0));
        send_tick(make_tick(ASCII_9, 1'b1, 1'b1));
        send_tick(make_tick(NO_KEY, 1'b0, 1'b0));
        send_tick(make_tick(NO_KEY, 1'b0, 1'b0));
        send_tick(make_tick(ASCII_0, 1'b0, 1'b0));
        send_tick(make_tick(NO_KEY, 1'b0, 1'b0));
    endtask

    task automatic test_random_hashes();
        while (ticks_sent < 160) begin
            idle_enable = ($urandom_range(0, 3) != 0);
            run_hash_cycle($urandom_range(0, 3) != 0);
        end
    endtask

    task automatic test_output_backpressure();
        idle_enable = 1'b0;
        hold_requests++;
        run_hash_cycle(1'b0);
    endtask

    task automatic test_quiet_tail();
        idle_enable = 1'b0;
        while (ticks_sent < 300) run_hash_cycle(1'b1);
    endtask

    initial begin
        key_phase      = KD_INIT;
        ctrl_phase     = CS_INIT;
        latched_key    = '0;
        key_pending    = 1'b0;
        stored_count   = 0;
        buf_full       = 1'b0;
        xfer_done      = 1'b0;
        engine_running = 1'b0;
        run_level      = 1'b0;
        foreach (hash_buf[i]) hash_buf[i] = ASCII_SP;

        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_key_edges();
        drain_results();
        test_random_hashes();
        drain_results();
        test_output_backpressure();
        drain_results();
        test_quiet_tail();
        drain_results();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
